[sv/lgrs_pkg.sv]
// Shared constants and types for the life generation row stream block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lgrs_pkg;

   // Width of a row on the stream ports
   localparam int ROW_BITS = 64;

   // Width of the active column count register
   localparam int COUNT_BITS = 7;

   // Default for the widest grid supported
   localparam int MAX_COLUMNS_DFLT = 64;

   // Active column count after reset: all columns in use
   localparam logic [COUNT_BITS-1:0] COLUMNS_RESET = 7'd64;

   // Entries in the job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Neighbour counts of the B3/S23 rule
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // What a queued job asks of the back end
   typedef struct packed {
      logic emit_mid;    // emit next generation of the middle row
      logic emit_final;  // emit next generation of the bottom row
   } job_flags_type;

   localparam int FLAG_BITS = $bits(job_flags_type);

endpackage

`default_nettype wire

[sv/life_generation_row_stream.sv]
// Top level of the life generation row stream: one B3/S23 generation, row by row.
// Depends on lgrs_pkg, lgrs_front, lgrs_queue and lgrs_back.
//
// Use:
//  - req channel carries the current generation, one row per word, top row first.
//    req_tuser marks the top row, req_tlast the bottom row. Cells outside the grid
//    are dead; nothing wraps around.
//  - rsp channel carries the next generation. A row's result leaves once the row
//    below it has arrived; a bottom row with a row pending gives two words, the
//    second with rsp_tlast set. A top row gives no word unless it is also the bottom row.
//  - csr_wr_en / csr_wr_data set the number of active columns (reset 64); write
//    it only while the block is idle. Columns at or above it read and emit dead.
// Timing:
//  - The word a row causes reaches rsp through a queue entry, then the output
//    register; a stall on rsp can hold it in the queue between the two.
//  - One row per cycle is taken while the queue has room; the output register
//    sends one word per cycle unless stalled, and a bottom row's words go in turn.
//  - When the receiver stalls, the output word holds and rows keep going into the
//    four-entry job queue; req_tready drops only when that queue is full or in reset.
// Reset: clears the pending rows, the queue, the output word and sets 64 columns.
`default_nettype none

module life_generation_row_stream #(
   parameter int MAX_COLUMNS = lgrs_pkg::MAX_COLUMNS_DFLT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input rows
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [lgrs_pkg::ROW_BITS-1:0]     req_tdata,   // [63:0] row_cells
   input  wire logic                              req_tuser,   // [0] first_row
   input  wire logic                              req_tlast,   // last_row
   // Next-generation rows
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lgrs_pkg::ROW_BITS-1:0]          rsp_tdata,   // [63:0] next_row_cells
   output logic                                   rsp_tlast,   // final_row
   // Active column count
   input  wire logic                              csr_wr_en,
   input  wire logic [lgrs_pkg::COUNT_BITS-1:0]   csr_wr_data
);
   import lgrs_pkg::*;

   localparam int JOB_BITS = 3 * MAX_COLUMNS + FLAG_BITS;

   logic [COUNT_BITS-1:0]  active_columns_ff;
   logic                   row_accept;
   logic                   job_push, job_pop;
   logic                   queue_not_full, queue_not_empty;
   logic [MAX_COLUMNS-1:0] push_up, push_mid, push_down;
   job_flags_type          push_flags;
   logic [JOB_BITS-1:0]    push_word, head_word;
   logic [MAX_COLUMNS-1:0] head_up, head_mid, head_down;
   job_flags_type          head_flags;
   logic [MAX_COLUMNS-1:0] out_cells;

   // Hold the column count; a count above MAX_COLUMNS acts as MAX_COLUMNS in the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         active_columns_ff <= COLUMNS_RESET;
      end else if (csr_wr_en) begin
         active_columns_ff <= csr_wr_data;
      end
   end

   // Take no row during reset so nothing slips past the cleared state
   assign req_tready = queue_not_full && !reset;
   assign row_accept = req_tvalid && req_tready;

   lgrs_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .row_accept (row_accept),
      .row_cells  (req_tdata[MAX_COLUMNS-1:0]),
      .first_row  (req_tuser),
      .last_row   (req_tlast),
      .job_push   (job_push),
      .job_up     (push_up),
      .job_mid    (push_mid),
      .job_down   (push_down),
      .job_flags  (push_flags)
   );

   assign push_word = {push_up, push_mid, push_down, push_flags};

   lgrs_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_word),
      .pop       (job_pop),
      .not_full  (queue_not_full),
      .not_empty (queue_not_empty),
      .head_data (head_word)
   );

   assign {head_up, head_mid, head_down, head_flags} = head_word;

   lgrs_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (queue_not_empty),
      .job_up         (head_up),
      .job_mid        (head_mid),
      .job_down       (head_down),
      .job_flags      (head_flags),
      .active_columns (active_columns_ff),
      .job_pop        (job_pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_cells      (out_cells),
      .out_final      (rsp_tlast)
   );

   // Widen to the port; columns beyond MAX_COLUMNS are dead
   assign rsp_tdata = ROW_BITS'(out_cells);

endmodule

`default_nettype wire

[sv/lgrs_front.sv]
// Front end: accepts rows, keeps the two previous rows and turns rows into jobs.
// Depends on lgrs_pkg.
`default_nettype none

module lgrs_front #(
   parameter int MAX_COLUMNS = lgrs_pkg::MAX_COLUMNS_DFLT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         row_accept,
   input  wire logic [MAX_COLUMNS-1:0]       row_cells,
   input  wire logic                         first_row,
   input  wire logic                         last_row,
   output logic                              job_push,
   output logic [MAX_COLUMNS-1:0]            job_up,
   output logic [MAX_COLUMNS-1:0]            job_mid,
   output logic [MAX_COLUMNS-1:0]            job_down,
   output lgrs_pkg::job_flags_type           job_flags
);
   import lgrs_pkg::*;

   logic [MAX_COLUMNS-1:0] above_ff, above_in;
   logic [MAX_COLUMNS-1:0] middle_ff, middle_in;
   logic                   middle_valid_ff, middle_valid_in;
   logic                   start_grid;

   // A top row, or any row with nothing pending, opens a new grid
   assign start_grid = first_row || !middle_valid_ff;

   always_comb begin
      above_in        = above_ff;
      middle_in       = middle_ff;
      middle_valid_in = middle_valid_ff;
      if (start_grid) begin
         job_up   = '0;
         job_mid  = '0;
      end else begin
         job_up   = above_ff;
         job_mid  = middle_ff;
      end
      job_down            = row_cells;
      job_flags.emit_mid   = !start_grid;
      job_flags.emit_final = last_row;
      job_push             = row_accept && (!start_grid || last_row);
      if (row_accept) begin
         above_in        = start_grid ? '0 : middle_ff;
         middle_in       = row_cells;
         middle_valid_in = 1'b1;
         if (last_row) begin
            above_in        = '0;
            middle_in       = '0;
            middle_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         middle_valid_ff <= 1'b0;
      end else begin
         middle_valid_ff <= middle_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      above_ff  <= above_in;
      middle_ff <= middle_in;
   end

endmodule

`default_nettype wire

[sv/lgrs_queue.sv]
// Short job queue between front and back end.
// Depends on lgrs_pkg for its depth.
`default_nettype none

module lgrs_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  not_full,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head_data
);
   import lgrs_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign not_full  = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/lgrs_back.sv]
// Back end: applies the B3/S23 rule to a queued job and holds the result word.
// Depends on lgrs_pkg.
`default_nettype none

module lgrs_back #(
   parameter int MAX_COLUMNS = lgrs_pkg::MAX_COLUMNS_DFLT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              job_valid,
   input  wire logic [MAX_COLUMNS-1:0]            job_up,
   input  wire logic [MAX_COLUMNS-1:0]            job_mid,
   input  wire logic [MAX_COLUMNS-1:0]            job_down,
   input  wire lgrs_pkg::job_flags_type           job_flags,
   input  wire logic [lgrs_pkg::COUNT_BITS-1:0]   active_columns,
   output logic                                   job_pop,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [MAX_COLUMNS-1:0]                 out_cells,
   output logic                                   out_final
);
   import lgrs_pkg::*;

   logic                   phase_ff, phase_in;
   logic                   valid_ff, valid_in;
   logic [MAX_COLUMNS-1:0] cells_ff;
   logic                   final_ff;
   logic                   use_mid, load;
   logic [MAX_COLUMNS-1:0] col_mask, up, mid, down, next_cells;
   logic [MAX_COLUMNS+1:0] up_pad, mid_pad, down_pad;
   logic [3:0]             neighbours [MAX_COLUMNS];

   // Middle-row result first, then the bottom-row result of the same job
   assign use_mid = job_flags.emit_mid && !phase_ff;
   assign load    = job_valid && (!valid_ff || out_ready);
   assign job_pop = load && !(use_mid && job_flags.emit_final);

   for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_mask
      assign col_mask[c] = (COUNT_BITS'(c) < active_columns);
   end

   always_comb begin
      up       = use_mid ? job_up : job_mid;
      mid      = use_mid ? job_mid : job_down;
      down     = use_mid ? job_down : '0;
      up_pad   = {1'b0, up & col_mask, 1'b0};
      mid_pad  = {1'b0, mid & col_mask, 1'b0};
      down_pad = {1'b0, down & col_mask, 1'b0};
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         neighbours[c] = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
                       + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
                       + 4'(down_pad[c]) + 4'(down_pad[c+1]) + 4'(down_pad[c+2]);
         // drop births just past the active width
         next_cells[c] = col_mask[c]
                       && ((neighbours[c] == BIRTH_COUNT)
                           || (mid_pad[c+1] && (neighbours[c] == SURVIVE_COUNT)));
      end
   end

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff;
      if (load) begin
         phase_in = use_mid && job_flags.emit_final;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cells_ff <= next_cells;
         final_ff <= !use_mid;
      end
   end

   assign out_valid = valid_ff;
   assign out_cells = cells_ff;
   assign out_final = final_ff;

endmodule

`default_nettype wire

[sv/lgrs_checker.sv]
// Port-level checks for life_generation_row_stream, attached by bind.
// Depends on lgrs_pkg for port widths.
`default_nettype none

module lgrs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          req_tlast,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [lgrs_pkg::ROW_BITS-1:0] rsp_tdata,
   input wire logic                          rsp_tlast
);
   import lgrs_pkg::*;

   // Drop the output word on reset
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Hold a stalled result word
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // A fresh output word comes from a row taken earlier, passed through the queue entry and the output register
   a_fresh_word_has_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result word without a row accepted two cycles earlier");

   // A bottom row always leaves a word waiting after the queue entry and the output register
   a_bottom_row_answers: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> ##1 rsp_tvalid)
      else $error("no result word after a bottom row");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (.*);

`default_nettype wire

[verif/lgrs_generation_checker.sv]
// Watching checker for the life generation row stream: predicts each next-generation word.
// Depends on lgrs_pkg; instantiated beside the block by tb_top.
`default_nettype none

module lgrs_generation_checker
   import lgrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [ROW_BITS-1:0]   req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [ROW_BITS-1:0]   rsp_tdata,
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [COUNT_BITS-1:0] csr_wr_data,
   output int                         mismatch_count,
   output int                         results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ROW_BITS-1:0] cells;
      logic                final_row;
   } gen_row_t;

   gen_row_t              gen_due[$];
   gen_row_t              oldest;
   logic [ROW_BITS-1:0]   upper_row;
   logic [ROW_BITS-1:0]   centre_row;
   logic                  centre_held;
   logic [COUNT_BITS-1:0] live_columns;
   int                    fail_total = 0;

   assign mismatch_count = fail_total;

   task automatic report_mismatch(input string msg);
      if (fail_total < 100)
         $display("%0t ns: mismatch: %s", $time, msg);
      fail_total++;
   endtask

   // B3/S23 on a bounded grid; columns at or above the count are dead going in and out
   function automatic logic [ROW_BITS-1:0] next_generation(input logic [ROW_BITS-1:0] up,
                                                           input logic [ROW_BITS-1:0] mid,
                                                           input logic [ROW_BITS-1:0] down,
                                                           input logic [COUNT_BITS-1:0] cols);
      logic [ROW_BITS-1:0] keep;
      logic [ROW_BITS-1:0] born;
      int                  n;
      int                  k;
      keep = (cols >= ROW_BITS) ? '1 : ((64'd1 << cols) - 64'd1);
      up   = up & keep;
      mid  = mid & keep;
      down = down & keep;
      born = '0;
      for (int c = 0; c < ROW_BITS; c++) begin
         n = 0;
         for (int d = -1; d <= 1; d++) begin
            k = c + d;
            if (k >= 0 && k < ROW_BITS) begin
               n += up[k] + down[k];
               if (d != 0)
                  n += mid[k];
            end
         end
         born[c] = (n == BIRTH_COUNT) || (mid[c] && n == SURVIVE_COUNT);
      end
      return born & keep;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gen_due.delete();
         upper_row    = '0;
         centre_row   = '0;
         centre_held  = 1'b0;
         live_columns = COLUMNS_RESET;
      end else begin
         // compare first: a word leaving now can never stem from a row taken now
         if (rsp_tvalid && rsp_tready) begin
            if (gen_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               oldest = gen_due.pop_front();
               if (rsp_tdata !== oldest.cells)
                  report_mismatch($sformatf("row cells %h, expected %h",
                                            rsp_tdata, oldest.cells));
               if (rsp_tlast !== oldest.final_row)
                  report_mismatch($sformatf("final flag %b, expected %b",
                                            rsp_tlast, oldest.final_row));
            end
         end
         if (csr_wr_en)
            live_columns = csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser || !centre_held) begin
               upper_row   = '0;
               centre_row  = req_tdata;
               centre_held = 1'b1;
            end else begin
               gen_due.push_back({next_generation(upper_row, centre_row, req_tdata,
                                                  live_columns), 1'b0});
               upper_row  = centre_row;
               centre_row = req_tdata;
            end
            if (req_tlast) begin
               gen_due.push_back({next_generation(upper_row, centre_row, '0,
                                                  live_columns), 1'b1});
               upper_row   = '0;
               centre_row  = '0;
               centre_held = 1'b0;
            end
         end
      end
      results_due <= gen_due.size();
   end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Testbench top for the life generation row stream: clock, reset, stimulus and verdict.
// Depends on lgrs_pkg, life_generation_row_stream and lgrs_generation_checker.
`default_nettype none

module tb_top;
   import lgrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ROWS = 1950;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [ROW_BITS-1:0]   req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [ROW_BITS-1:0]   rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;

   int                    mismatch_count;
   int                    results_due;

   // sender pacing: rows left in the current burst and how eagerly gaps are drawn
   int                    burst_left  = 0;
   int                    idle_level  = 0;

   // receiver stall pattern: rotated every cycle, redrawn now and then
   bit                    stall_on    = 1'b0;
   logic [15:0]           stall_pattern = 16'hFFFF;
   int                    stall_age   = 0;

   always #4 clock = ~clock;

   life_generation_row_stream DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [63:0] row_cells
      .req_tuser   (req_tuser),    // [0] first_row
      .req_tlast   (req_tlast),    // last_row
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [63:0] next_row_cells
      .rsp_tlast   (rsp_tlast),    // final_row
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lgrs_generation_checker gen_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // Receiver: always ready when stalling is off, otherwise follow the rotating
   // pattern; redraw it whenever stall_age wraps so stalls drift across the block's phases.
   always @(negedge clock) begin
      if (!stall_on) begin
         rsp_tready <= 1'b1;
      end else begin
         if (stall_age == 0)
            stall_pattern = 16'(($urandom_range(0, 1) ? $urandom : ($urandom & $urandom))
                                | 32'h1);
         rsp_tready    <= stall_pattern[0];
         stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
      end
      stall_age = (stall_age + 1) % 48;
   end

   // Offer one row word and hold it until the block takes it. Between bursts, if
   // idle_level is not zero, valid may drop for a random gap; within a burst it stays high.
   task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic first,
                           input logic last);
      int gap;
      gap = 0;
      @(negedge clock);
      if (burst_left == 0) begin
         if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 4 : 1) == 0)
            gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cells;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Let the block drain, allow for rows still in flight that cause no word,
   // then write the active column count.
   task automatic set_columns(input logic [COUNT_BITS-1:0] cols);
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left  = 0;
      while (results_due != 0) @(posedge clock);
      repeat (8) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cols;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix of densities so that births, survivals and deaths all occur often
   function automatic logic [ROW_BITS-1:0] random_row();
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return a & b;
         3:       return a | b;
         4:       return a & b & {$urandom, $urandom};
         5:       return 64'h7 << $urandom_range(0, 61);
         default: return a;
      endcase
   endfunction

   initial begin
      logic [COUNT_BITS-1:0] phase_columns[10];
      int                    per_phase;
      int                    sent;
      int                    rows;
      bit                    noisy;
      logic                  first;
      logic                  last;

      // full width, narrowest, saturation above the maximum, all columns dead
      phase_columns = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd127, 7'd0, 7'd65, 7'd17, 7'd63, 7'd40};
      phase_columns[9] = COUNT_BITS'($urandom_range(1, 64));
      per_phase = RANDOM_ROWS / 10;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at full width, no idling on either side
      set_columns(7'd64);
      // single-row grids: dead above and below
      send_row('1, 1'b1, 1'b1);
      send_row('0, 1'b1, 1'b1);
      // blinker in the middle of the grid
      send_row('0, 1'b1, 1'b0);
      send_row(64'h7 << 30, 1'b0, 1'b0);
      send_row('0, 1'b0, 1'b1);
      // cells on both edge columns: nothing may wrap around
      send_row(64'h8000_0000_0000_0001, 1'b1, 1'b0);
      send_row(64'hC000_0000_0000_0003, 1'b0, 1'b0);
      send_row(64'h8000_0000_0000_0001, 1'b0, 1'b1);
      // fully alive grid
      send_row('1, 1'b1, 1'b0);
      send_row('1, 1'b0, 1'b0);
      send_row('1, 1'b0, 1'b1);
      // alternating columns
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
      send_row(64'h5555_5555_5555_5555, 1'b0, 1'b0);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1);
      // a second top row drops the pending one and starts afresh
      send_row(64'hF0, 1'b1, 1'b0);
      send_row(64'h0F0F, 1'b1, 1'b0);
      send_row(64'h1C, 1'b0, 1'b0);
      send_row(64'h38, 1'b0, 1'b1);
      // rows without the top flag while nothing is pending start a grid
      send_row(64'h700, 1'b0, 1'b0);
      send_row(64'h700, 1'b0, 1'b1);
      send_row(64'hFFFF, 1'b0, 1'b1);
      // single-row grid arriving while a row is pending
      send_row(64'h3, 1'b1, 1'b0);
      send_row(64'h6, 1'b1, 1'b1);

      // Random part: one phase per column setting, pacing redrawn per phase
      for (int p = 0; p < 10; p++) begin
         set_columns(phase_columns[p]);
         idle_level = (p == 0) ? 0 : $urandom_range(0, 2);
         stall_on   = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < per_phase) begin
            rows  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            noisy = ($urandom_range(0, 6) == 0);
            for (int r = 0; r < rows; r++) begin
               first = (r == 0);
               last  = (r == rows - 1);
               // broken grids: stray, missing or repeated top and bottom flags
               if (noisy) begin
                  first = ($urandom_range(0, 4) == 0);
                  last  = ($urandom_range(0, 4) == 0);
               end
               send_row(random_row(), first, last);
               sent++;
            end
         end
      end

      // Drain: hold valid low, wait for every word, then the pipeline latency
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_due != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // Watchdog well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

`default_nettype wire
